/* rtl/assert_macros.svh */
// Concurrent assertion helpers for the RTL files; wkpq_back includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The property must hold at every clock edge outside reset.
`define WKPQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// The expression must never be true outside reset.
`define WKPQ_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`else

`define WKPQ_ASSERT(label, clk, rst, prop, msg)

`define WKPQ_NEVER(label, clk, rst, expr, msg)

`endif

`endif

/* rtl/wkpq_pkg.sv */
`timescale 1ns / 1ps

package wkpq_pkg;

   localparam int ELEMENT_WIDTH = 16;
   localparam int GRADE_WIDTH   = 16;
   localparam int COUNT_WIDTH   = 8;
   localparam int KEY_WIDTH     = 32;
   localparam int WEIGHT_WIDTH  = 24;
   localparam int ENTRIES_WIDTH = 5;
   localparam int STATUS_WIDTH  = 2;

   localparam int GRADE_PROD_WIDTH = GRADE_WIDTH + WEIGHT_WIDTH;
   localparam int COUNT_PROD_WIDTH = COUNT_WIDTH + WEIGHT_WIDTH;
   localparam int SUM_WIDTH        = GRADE_PROD_WIDTH + 1;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_GRADE_WEIGHT = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_COUNT_WEIGHT = 1'd1;

   localparam logic [WEIGHT_WIDTH-1:0] GRADE_WEIGHT_RESET = 24'd5033;
   localparam logic [WEIGHT_WIDTH-1:0] COUNT_WEIGHT_RESET = 24'd293601;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_WIDTH-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_POP_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_PUSH_FULL = 2'd2;

   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_WIDTH = 1;
   localparam int QUEUE_CNT_WIDTH = 2;

   typedef struct packed {
      logic [ELEMENT_WIDTH-1:0] element;
      logic [GRADE_WIDTH-1:0]   grade;
      logic [COUNT_WIDTH-1:0]   count;
      logic [KEY_WIDTH-1:0]     key;
   } entry_type;

   typedef struct packed {
      logic      op;
      entry_type entry;
   } cmd_type;

   typedef struct packed {
      entry_type                 head;
      logic [ENTRIES_WIDTH-1:0]  entries;
      logic                      is_empty;
      logic [STATUS_WIDTH-1:0]   status;
   } rsp_type;

endpackage

/* rtl/wkpq_fifo.sv */
`timescale 1ns / 1ps

module wkpq_fifo
   import wkpq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_cmd,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_cmd
);

   cmd_type                    entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_WIDTH-1:0] count_ff, count_in;
   logic                       do_push, do_pop;

   assign push_ready = count_ff != QUEUE_CNT_WIDTH'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_cmd    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

/* rtl/wkpq_front.sv */
`timescale 1ns / 1ps

module wkpq_front
   import wkpq_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic [ELEMENT_WIDTH-1:0]   req_element,
   input  logic [GRADE_WIDTH-1:0]     req_grade,
   input  logic [COUNT_WIDTH-1:0]     req_approved_count,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WEIGHT_WIDTH-1:0]    csr_wdata,
   output logic                       cmd_valid,
   input  logic                       cmd_ready,
   output cmd_type                    cmd
);

   logic [WEIGHT_WIDTH-1:0]     grade_weight_ff, grade_weight_in;
   logic [WEIGHT_WIDTH-1:0]     count_weight_ff, count_weight_in;
   logic                        s1_valid_ff, s1_valid_in;
   logic                        s1_op_ff;
   logic [ELEMENT_WIDTH-1:0]    s1_element_ff;
   logic [GRADE_WIDTH-1:0]      s1_grade_ff;
   logic [COUNT_WIDTH-1:0]      s1_count_ff;
   logic [GRADE_PROD_WIDTH-1:0] grade_prod_ff;
   logic [COUNT_PROD_WIDTH-1:0] count_prod_ff;
   logic [SUM_WIDTH-1:0]        key_sum;
   logic                        take;

   always_comb begin
      grade_weight_in = grade_weight_ff;
      count_weight_in = count_weight_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_GRADE_WEIGHT: grade_weight_in = csr_wdata;
            REG_COUNT_WEIGHT: count_weight_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage one holds the two products; the sum and saturation feed the queue.
   assign req_ready = !s1_valid_ff || cmd_ready;
   assign take      = req_valid && req_ready;
   assign cmd_valid = s1_valid_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (take) begin
         s1_valid_in = 1'b1;
      end else if (cmd_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   assign key_sum = {1'b0, grade_prod_ff}
                  + SUM_WIDTH'(count_prod_ff);

   always_comb begin
      cmd.op            = s1_op_ff;
      cmd.entry.element = s1_element_ff;
      cmd.entry.grade   = s1_grade_ff;
      cmd.entry.count   = s1_count_ff;
      if (key_sum[SUM_WIDTH-1:KEY_WIDTH] != '0) begin
         cmd.entry.key = '1;
      end else begin
         cmd.entry.key = key_sum[KEY_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grade_weight_ff <= GRADE_WEIGHT_RESET;
         count_weight_ff <= COUNT_WEIGHT_RESET;
         s1_valid_ff     <= 1'b0;
      end else begin
         grade_weight_ff <= grade_weight_in;
         count_weight_ff <= count_weight_in;
         s1_valid_ff     <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_op_ff      <= req_operation;
         s1_element_ff <= req_element;
         s1_grade_ff   <= req_grade;
         s1_count_ff   <= req_approved_count;
         grade_prod_ff <= GRADE_PROD_WIDTH'(req_grade) * GRADE_PROD_WIDTH'(grade_weight_ff);
         count_prod_ff <= COUNT_PROD_WIDTH'(req_approved_count)
                        * COUNT_PROD_WIDTH'(count_weight_ff);
      end
   end

endmodule

/* rtl/wkpq_back.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wkpq_back
   import wkpq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   localparam int FILL_WIDTH = $clog2(CAPACITY + 1);

   entry_type               slot_ff [CAPACITY];
   entry_type               slot_in [CAPACITY];
   logic [CAPACITY-1:0]     ahead;
   logic [FILL_WIDTH-1:0]   fill_ff, fill_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    take, full, empty, do_push, do_pop;

   assign full      = fill_ff == FILL_WIDTH'(CAPACITY);
   assign empty     = fill_ff == '0;
   assign cmd_ready = !rsp_valid_ff || rsp_ready;
   assign take      = cmd_valid && cmd_ready;
   assign do_push   = take && (cmd.op == OP_PUSH) && !full;
   assign do_pop    = take && (cmd.op == OP_POP) && !empty;

   // Each cell compares its key with the new one; the stored order makes the
   // set of cells that stay ahead of the new entry a prefix of the list.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign ahead[i] = (FILL_WIDTH'(i) < fill_ff) && (slot_ff[i].key > cmd.entry.key);

      always_comb begin
         slot_in[i] = slot_ff[i];
         if (do_push && !ahead[i]) begin
            if (i == 0) begin
               slot_in[i] = cmd.entry;
            end else if (ahead[(i == 0) ? 0 : i - 1]) begin
               slot_in[i] = cmd.entry;
            end else begin
               slot_in[i] = slot_ff[(i == 0) ? 0 : i - 1];
            end
         end else if (do_pop && (i < CAPACITY - 1)) begin
            slot_in[i] = slot_ff[(i < CAPACITY - 1) ? i + 1 : i];
         end
      end
   end

   always_comb begin
      fill_in = fill_ff;
      if (do_push) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_in.status = STATUS_OK;
      if (cmd.op == OP_PUSH && full) begin
         rsp_in.status = STATUS_PUSH_FULL;
      end else if (cmd.op == OP_POP && empty) begin
         rsp_in.status = STATUS_POP_EMPTY;
      end
      rsp_in.entries  = ENTRIES_WIDTH'(fill_in);
      rsp_in.is_empty = fill_in == '0;
      rsp_in.head     = (fill_in == '0) ? '0 : slot_in[0];
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
      if (do_push || do_pop) begin
         for (int i = 0; i < CAPACITY; i++) begin
            slot_ff[i] <= slot_in[i];
         end
      end
   end

   `WKPQ_NEVER(a_fill_bound, clock, reset, fill_ff > FILL_WIDTH'(CAPACITY), "fill level above capacity")
   `WKPQ_ASSERT(a_head_sorted, clock, reset, (fill_ff >= FILL_WIDTH'(2)) |-> (slot_ff[0].key >= slot_ff[1].key), "head key below second key")
   `WKPQ_ASSERT(a_push_grows, clock, reset, do_push |=> (fill_ff == $past(fill_ff) + 1'b1), "accepted push did not grow the list")
   `WKPQ_ASSERT(a_reject_holds, clock, reset, (take && cmd.op == OP_PUSH && full) |=> (fill_ff == $past(fill_ff)), "rejected push changed the fill level")

endmodule

/* rtl/weighted_key_priority_queue_unit.sv */
`timescale 1ns / 1ps
// Channel  Handshake             Payload
// req      req_valid/req_ready   operation, element, grade, approved_count
// rsp      rsp_valid/rsp_ready   head fields, entries, is_empty, status
// csr      csr_write_enable      csr_index, csr_wdata (no wait)
//
// Sustained rate is one item per cycle while rsp_ready stays high; a req transfer
// reaches rsp_valid via the product register, command queue and result register.
// The front computes the key while the back updates all cells together.
// Reset is synchronous and empties the list; slot contents are not cleared.
// A stalled rsp backs up into the queue, then into the front and req_ready.

module weighted_key_priority_queue_unit
   import wkpq_pkg::*;
#(
   parameter int CAPACITY = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_operation,
   input  logic [ELEMENT_WIDTH-1:0]   req_element,
   input  logic [GRADE_WIDTH-1:0]     req_grade,
   input  logic [COUNT_WIDTH-1:0]     req_approved_count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ELEMENT_WIDTH-1:0]   rsp_head_element,
   output logic [GRADE_WIDTH-1:0]     rsp_head_grade,
   output logic [COUNT_WIDTH-1:0]     rsp_head_count,
   output logic [KEY_WIDTH-1:0]       rsp_head_key,
   output logic [ENTRIES_WIDTH-1:0]   rsp_entries,
   output logic                       rsp_is_empty,
   output logic [STATUS_WIDTH-1:0]    rsp_status,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WEIGHT_WIDTH-1:0]    csr_wdata
);

   logic    front_valid, front_ready;
   cmd_type front_cmd;
   logic    queue_valid, queue_ready;
   cmd_type queue_cmd;
   rsp_type rsp;

   wkpq_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_element        (req_element),
      .req_grade          (req_grade),
      .req_approved_count (req_approved_count),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .cmd_valid          (front_valid),
      .cmd_ready          (front_ready),
      .cmd                (front_cmd)
   );

   wkpq_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_cmd   (front_cmd),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_cmd    (queue_cmd)
   );

   wkpq_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (queue_valid),
      .cmd_ready (queue_ready),
      .cmd       (queue_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_head_element = rsp.head.element;
   assign rsp_head_grade   = rsp.head.grade;
   assign rsp_head_count   = rsp.head.count;
   assign rsp_head_key     = rsp.head.key;
   assign rsp_entries      = rsp.entries;
   assign rsp_is_empty     = rsp.is_empty;
   assign rsp_status       = rsp.status;

endmodule

/* dv/tb_weighted_key_priority_queue_unit.sv */
`timescale 1ns / 1ps

module tb_weighted_key_priority_queue_unit;
   import wkpq_pkg::*;

   localparam int CAPACITY       = 16;
   localparam int IDLE_PCT       = 37;
   localparam int MAX_REPORTS    = 10;
   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASE_COUNT    = 6;
   localparam int PHASE_ITEMS    = 250;
   localparam int TIMEOUT_CYCLES = 1_000_000;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic                       op;
      logic [ELEMENT_WIDTH-1:0]   element;
      logic [GRADE_WIDTH-1:0]     grade;
      logic [COUNT_WIDTH-1:0]     count;
      logic [7:0]                 reps;
      rsp_type                    want;
      logic [CSR_INDEX_WIDTH-1:0] csr_sel;
      logic [WEIGHT_WIDTH-1:0]    csr_value;
   } plan_row_type;

   // An all-zero report never occurs (entries 0 always comes with is_empty set), so it marks
   // rows whose result comes from the predictor.
   localparam rsp_type PREDICTED = '0;
   localparam rsp_type EMPTY_REFUSED =
      '{head: '0, entries: '0, is_empty: 1'b1, status: STATUS_POP_EMPTY};
   localparam rsp_type EMPTY_OK =
      '{head: '0, entries: '0, is_empty: 1'b1, status: STATUS_OK};
   localparam rsp_type ZERO_KEY_HEAD =
      '{head: '{16'hFFFF, 16'h0000, 8'h00, 32'h0000_0000}, entries: 5'd1, is_empty: 1'b0,
        status: STATUS_OK};
   localparam rsp_type SATURATED_HEAD =
      '{head: '{16'hAAAA, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, entries: 5'd1, is_empty: 1'b0,
        status: STATUS_OK};
   localparam rsp_type SATURATED_HEAD_2 =
      '{head: '{16'hAAAA, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF}, entries: 5'd2, is_empty: 1'b0,
        status: STATUS_OK};

   localparam plan_row_type PLAN [27] = '{
      '{ROW_ITEM, OP_POP,  16'h0000, 16'h0000, 8'h00, 8'd1,  EMPTY_REFUSED, REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'hFFFF, 16'h0000, 8'h00, 8'd1,  ZERO_KEY_HEAD, REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_POP,  16'h0000, 16'h0000, 8'h00, 8'd1,  EMPTY_OK,      REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h0001, 16'hFFFF, 8'hFF, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h0002, 16'h0001, 8'h00, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h0003, 16'h0000, 8'h01, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h0004, 16'h0000, 8'h00, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h0005, 16'h0000, 8'h00, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_POP,  16'h0000, 16'h0000, 8'h00, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      // Twelve equal keys fill the list and must leave in reverse order.
      '{ROW_ITEM, OP_PUSH, 16'h0100, 16'h04D2, 8'h11, 8'd12, PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h0200, 16'h0000, 8'h00, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h0300, 16'hFFFF, 8'hFF, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_POP,  16'h0000, 16'h0000, 8'h00, 8'd16, PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_POP,  16'hFFFF, 16'hFFFF, 8'hFF, 8'd1,  EMPTY_REFUSED, REG_GRADE_WEIGHT, '0},
      '{ROW_CSR,  OP_PUSH, 16'h0000, 16'h0000, 8'h00, 8'd0,  PREDICTED,     REG_GRADE_WEIGHT,
        24'hFFFFFF},
      '{ROW_CSR,  OP_PUSH, 16'h0000, 16'h0000, 8'h00, 8'd0,  PREDICTED,     REG_COUNT_WEIGHT,
        24'hFFFFFF},
      '{ROW_ITEM, OP_PUSH, 16'hAAAA, 16'hFFFF, 8'hFF, 8'd1,  SATURATED_HEAD,   REG_GRADE_WEIGHT,
        '0},
      '{ROW_ITEM, OP_PUSH, 16'h5555, 16'h0000, 8'h00, 8'd1,  SATURATED_HEAD_2, REG_GRADE_WEIGHT,
        '0},
      '{ROW_ITEM, OP_PUSH, 16'h0010, 16'h0100, 8'h00, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h0011, 16'h0101, 8'h00, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h0012, 16'h0000, 8'hFF, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_CSR,  OP_PUSH, 16'h0000, 16'h0000, 8'h00, 8'd0,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_CSR,  OP_PUSH, 16'h0000, 16'h0000, 8'h00, 8'd0,  PREDICTED,     REG_COUNT_WEIGHT, '0},
      '{ROW_ITEM, OP_PUSH, 16'h1234, 16'hFFFF, 8'hFF, 8'd1,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_ITEM, OP_POP,  16'h0000, 16'h0000, 8'h00, 8'd7,  PREDICTED,     REG_GRADE_WEIGHT, '0},
      '{ROW_CSR,  OP_PUSH, 16'h0000, 16'h0000, 8'h00, 8'd0,  PREDICTED,     REG_GRADE_WEIGHT,
        GRADE_WEIGHT_RESET},
      '{ROW_CSR,  OP_PUSH, 16'h0000, 16'h0000, 8'h00, 8'd0,  PREDICTED,     REG_COUNT_WEIGHT,
        COUNT_WEIGHT_RESET}
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic                       req_operation = OP_PUSH;
   logic [ELEMENT_WIDTH-1:0]   req_element = '0;
   logic [GRADE_WIDTH-1:0]     req_grade = '0;
   logic [COUNT_WIDTH-1:0]     req_approved_count = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [ELEMENT_WIDTH-1:0]   rsp_head_element;
   logic [GRADE_WIDTH-1:0]     rsp_head_grade;
   logic [COUNT_WIDTH-1:0]     rsp_head_count;
   logic [KEY_WIDTH-1:0]       rsp_head_key;
   logic [ENTRIES_WIDTH-1:0]   rsp_entries;
   logic                       rsp_is_empty;
   logic [STATUS_WIDTH-1:0]    rsp_status;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = REG_GRADE_WEIGHT;
   logic [WEIGHT_WIDTH-1:0]    csr_wdata = '0;

   // Typed result that travels with the request in flight, or PREDICTED.
   rsp_type pinned_head = PREDICTED;

   logic [WEIGHT_WIDTH-1:0] weight_per_grade = GRADE_WEIGHT_RESET;
   logic [WEIGHT_WIDTH-1:0] weight_per_course = COUNT_WEIGHT_RESET;
   entry_type ranked_entries [$];
   rsp_type   pending_heads [$];

   bit sender_idle = 1'b1;
   bit receiver_idle = 1'b1;
   int hold_requests = 0;
   int hold_seen = 0;
   int hold_left = 0;
   int mismatches = 0;

   weighted_key_priority_queue_unit #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_operation(req_operation),
      .req_element(req_element),
      .req_grade(req_grade),
      .req_approved_count(req_approved_count),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_head_element(rsp_head_element),
      .rsp_head_grade(rsp_head_grade),
      .rsp_head_count(rsp_head_count),
      .rsp_head_key(rsp_head_key),
      .rsp_entries(rsp_entries),
      .rsp_is_empty(rsp_is_empty),
      .rsp_status(rsp_status),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [KEY_WIDTH-1:0] weighted_key(logic [GRADE_WIDTH-1:0] grade,
                                                         logic [COUNT_WIDTH-1:0] count);
      logic [63:0] sum;
      sum = 64'(grade) * 64'(weight_per_grade) + 64'(count) * 64'(weight_per_course);
      return (sum > 64'hFFFF_FFFF) ? '1 : sum[KEY_WIDTH-1:0];
   endfunction

   // Applies one request to the sorted list and reports the head that follows.
   function automatic rsp_type next_head_report(logic op, logic [ELEMENT_WIDTH-1:0] element,
                                                logic [GRADE_WIDTH-1:0] grade,
                                                logic [COUNT_WIDTH-1:0] count);
      entry_type fresh;
      rsp_type   report;
      int        pos;
      report = '0;
      report.status = STATUS_OK;
      if (op == OP_PUSH) begin
         if (ranked_entries.size() >= CAPACITY) begin
            report.status = STATUS_PUSH_FULL;
         end else begin
            fresh.element = element;
            fresh.grade = grade;
            fresh.count = count;
            fresh.key = weighted_key(grade, count);
            pos = 0;
            while (pos < ranked_entries.size() && ranked_entries[pos].key > fresh.key)
               pos++;
            ranked_entries.insert(pos, fresh);
         end
      end else if (ranked_entries.size() == 0) begin
         report.status = STATUS_POP_EMPTY;
      end else begin
         void'(ranked_entries.pop_front());
      end
      if (ranked_entries.size() != 0)
         report.head = ranked_entries[0];
      report.entries = ENTRIES_WIDTH'(ranked_entries.size());
      report.is_empty = (ranked_entries.size() == 0);
      return report;
   endfunction

   // Tracks register writes and request transfers in the order the block sees them.
   always @(posedge clock) begin : track_requests
      rsp_type predicted;
      if (!reset) begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_GRADE_WEIGHT: weight_per_grade = csr_wdata;
               REG_COUNT_WEIGHT: weight_per_course = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            predicted = next_head_report(req_operation, req_element, req_grade,
                                         req_approved_count);
            pending_heads.push_back(pinned_head != PREDICTED ? pinned_head : predicted);
         end
      end
   end

   always @(posedge clock) begin : check_heads
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_heads.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: rsp transfer with no result outstanding", $time);
         end else begin
            want = pending_heads.pop_front();
            if (rsp_head_element !== want.head.element || rsp_head_grade !== want.head.grade ||
                rsp_head_count !== want.head.count || rsp_head_key !== want.head.key ||
                rsp_entries !== want.entries || rsp_is_empty !== want.is_empty ||
                rsp_status !== want.status) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: expected elem=%h grade=%h count=%h key=%h n=%0d empty=%b st=%0d",
                           $time, want.head.element, want.head.grade, want.head.count,
                           want.head.key, want.entries, want.is_empty, want.status);
                  $display("%0t: actual   elem=%h grade=%h count=%h key=%h n=%0d empty=%b st=%0d",
                           $time, rsp_head_element, rsp_head_grade, rsp_head_count,
                           rsp_head_key, rsp_entries, rsp_is_empty, rsp_status);
               end
            end
         end
      end
   end

   // The long hold-off is counted here so that the sender keeps offering meanwhile.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_seen != hold_requests) begin
         hold_seen <= hold_requests;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !receiver_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic send_request(logic op, logic [ELEMENT_WIDTH-1:0] element,
                               logic [GRADE_WIDTH-1:0] grade, logic [COUNT_WIDTH-1:0] count,
                               rsp_type want);
      while (sender_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_element <= element;
      req_grade <= grade;
      req_approved_count <= count;
      pinned_head <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // Stops offering and waits until every outstanding result has been transferred.
   // The first wait lets the tracker record a transfer made at the edge just passed.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_heads.size() != 0)
         @(negedge clock);
      @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_weight(logic [CSR_INDEX_WIDTH-1:0] sel, logic [WEIGHT_WIDTH-1:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= sel;
      csr_wdata <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      logic                     op;
      logic [GRADE_WIDTH-1:0]   grade;
      logic [COUNT_WIDTH-1:0]   count;
      logic [WEIGHT_WIDTH-1:0]  grade_w;
      logic [WEIGHT_WIDTH-1:0]  count_w;
      int                       push_pct;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (PLAN[r]) begin
         if (PLAN[r].kind == ROW_CSR) begin
            wait_drained();
            write_weight(PLAN[r].csr_sel, PLAN[r].csr_value);
         end else begin
            for (int k = 0; k < PLAN[r].reps; k++)
               send_request(PLAN[r].op, PLAN[r].element + ELEMENT_WIDTH'(k), PLAN[r].grade,
                            PLAN[r].count, PLAN[r].want);
         end
      end

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin grade_w = GRADE_WEIGHT_RESET; count_w = COUNT_WEIGHT_RESET; end
            1: begin grade_w = '1; count_w = '1; end
            2: begin grade_w = '0; count_w = WEIGHT_WIDTH'($urandom); end
            3: begin grade_w = WEIGHT_WIDTH'($urandom); count_w = '0; end
            4: begin grade_w = 24'd1; count_w = 24'd1; end
            default: begin grade_w = WEIGHT_WIDTH'($urandom); count_w = WEIGHT_WIDTH'($urandom); end
         endcase
         wait_drained();
         write_weight(REG_GRADE_WEIGHT, grade_w);
         write_weight(REG_COUNT_WEIGHT, count_w);
         // Phase 1 runs without any idling; phase 2 opens with a long rsp stall.
         receiver_idle <= (phase != 1);
         if (phase == 2)
            hold_requests <= hold_requests + 1;
         push_pct = 85;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            sender_idle = (phase != 1) && !(phase == 2 && n < 60);
            if (n == PHASE_ITEMS / 2)
               wait_drained();
            if (n % 40 == 0)
               case ($urandom_range(2))
                  0: push_pct = 85;
                  1: push_pct = 50;
                  default: push_pct = 20;
               endcase
            op = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            // Small grades and counts make equal keys common.
            case ($urandom_range(3))
               0: grade = $urandom_range(1) ? '1 : '0;
               1: grade = GRADE_WIDTH'($urandom_range(3));
               default: grade = GRADE_WIDTH'($urandom);
            endcase
            case ($urandom_range(3))
               0: count = $urandom_range(1) ? '1 : '0;
               1: count = COUNT_WIDTH'($urandom_range(3));
               default: count = COUNT_WIDTH'($urandom);
            endcase
            send_request(op, ELEMENT_WIDTH'($urandom), grade, count, PREDICTED);
         end
      end

      wait_drained();
      if (mismatches == 0 && pending_heads.size() == 0)
         $display("tb_weighted_key_priority_queue_unit: done, clean");
      else
         $display("tb_weighted_key_priority_queue_unit: done, errors");
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 4);
      $display("tb_weighted_key_priority_queue_unit: done, errors");
      $finish;
   end

endmodule
